FILE: rtl/lhcs_pkg.sv
// shared codes, constants and a decode helper for the link handshake command supervisor
`default_nettype none
package lhcs_pkg;

	// link phase codes
	localparam logic [1:0] PH_UNLINKED = 2'd0;
	localparam logic [1:0] PH_RUNNING  = 2'd1;
	localparam logic [1:0] PH_BLOCKED  = 2'd2;

	// last recognized message
	localparam logic [1:0] MSG_NONE     = 2'd0;
	localparam logic [1:0] MSG_ACCEPTED = 2'd1;
	localparam logic [1:0] MSG_COMMAND  = 2'd2;

	// transmit request codes
	localparam logic [2:0] TX_NONE   = 3'd0;
	localparam logic [2:0] TX_CONREQ = 3'd1;
	localparam logic [2:0] TX_ECHO   = 3'd2;
	localparam logic [2:0] TX_REFRSH = 3'd3;
	localparam logic [2:0] TX_BLCKST = 3'd4;

	// "<CONACC>" with byte 0 in the low bits
	localparam logic [63:0] ACCEPT_TEXT = 64'h3E43_4341_4E4F_433C;

	localparam logic [7:0] CHAR_M     = 8'h4D;
	localparam logic [7:0] CHAR_S     = 8'h53;
	localparam logic [7:0] ASCII_ZERO = 8'd48;

	localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

	// two ascii digits to a value, wrapped to eight bits
	function automatic logic [7:0] digit_pair(input logic [7:0] hi, input logic [7:0] lo);
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] a_x10;
		a     = hi - ASCII_ZERO;
		b     = lo - ASCII_ZERO;
		a_x10 = {a[4:0], 3'b000} + {a[6:0], 1'b0};
		return a_x10 + b;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/link_handshake_command_supervisor.sv
// top level of the link handshake and command supervisor
//
// usage: one input item per poll tick carries the latest receive frame, its
// new-frame flag and the idle time since the last frame. in_valid/in_stall
// moves an item in, out_valid/out_stall moves one result item out, exactly
// one result per input item, in order.
// the configuration channel (cfg_valid/cfg_ready/cfg_data) writes the link
// timeout; cfg_ready is always high and writes are expected only while idle.
// an accepted item enters the input register, then its decode and phase
// update land in the output register, where out_valid rises.
// throughput: one item per cycle while out_stall does not hold the output;
// the decode and the three-phase update are a single level of logic between
// the input register and the output register.
// reset: phase unlinked, no message seen, motor/servo values and led cleared,
// timeout back to 1000, both pipeline registers empty.
// a stalled receiver holds the output register; the input register still
// takes one item, then in_stall rises until the output drains.
`default_nettype none
module link_handshake_command_supervisor
	import lhcs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data,
	// input items
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] rx_frame,
	input  wire logic        frame_is_new,
	input  wire logic [31:0] idle_time,
	// result items
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       tx_kind,
	output logic [63:0]      tx_echo,
	output logic             actuator_send,
	output logic [7:0]       motor_cmd,
	output logic [7:0]       servo_cmd,
	output logic             stop_actuators,
	output logic             led_on,
	output logic [1:0]       link_state
);

	// configuration
	logic [31:0] timeout_q;

	// input register
	logic        valid_s1;
	logic [63:0] frame_s1;
	logic        new_s1;
	logic [31:0] idle_s1;

	// supervisor state
	logic [1:0] phase_q;
	logic [1:0] msg_q;
	logic [7:0] motor_q;
	logic [7:0] servo_q;
	logic       led_q;

	// next values from this tick's decode
	logic [1:0]  msg_d;
	logic [7:0]  motor_d;
	logic [7:0]  servo_d;
	logic [1:0]  phase_d;
	logic        led_d;
	logic [2:0]  kind_d;
	logic [63:0] echo_d;
	logic        send_d;
	logic        stop_d;

	logic advance;
	logic in_take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			timeout_q <= cfg_data;
		end
	end

	// the item in s1 moves on when the output register is free or draining
	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			frame_s1 <= rx_frame;
			new_s1   <= frame_is_new;
			idle_s1  <= idle_time;
		end
	end

	// frame decode: exact accept text, else a command frame with M and S markers
	always_comb begin
		msg_d   = msg_q;
		motor_d = motor_q;
		servo_d = servo_q;
		if (frame_s1 == ACCEPT_TEXT) begin
			msg_d = MSG_ACCEPTED;
		end else if (frame_s1[15:8] == CHAR_M && frame_s1[39:32] == CHAR_S) begin
			msg_d   = MSG_COMMAND;
			motor_d = digit_pair(frame_s1[23:16], frame_s1[31:24]);
			servo_d = digit_pair(frame_s1[47:40], frame_s1[55:48]);
		end
	end

	// phase update and transmit choice
	always_comb begin
		phase_d = phase_q;
		led_d   = led_q;
		kind_d  = TX_NONE;
		echo_d  = '0;
		send_d  = 1'b0;
		stop_d  = 1'b0;
		unique case (phase_q)
			PH_UNLINKED: begin
				kind_d = TX_CONREQ;
				if (msg_d == MSG_ACCEPTED) begin
					phase_d = PH_RUNNING;
					led_d   = !led_q;
				end
			end
			PH_BLOCKED: begin
				if (new_s1) begin
					kind_d  = TX_REFRSH;
					led_d   = !led_q;
					send_d  = 1'b1;
					phase_d = PH_RUNNING;
				end else begin
					kind_d = TX_BLCKST;
					stop_d = 1'b1;
				end
			end
			default: begin
				// running, and the unused code behaves the same way
				if (new_s1) begin
					led_d  = !led_q;
					send_d = 1'b1;
					kind_d = TX_ECHO;
					echo_d = frame_s1;
				end else if (idle_s1 >= timeout_q) begin
					led_d   = 1'b1;
					phase_d = PH_BLOCKED;
				end
			end
		endcase
	end

	// state commits only when the item's result is captured
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_UNLINKED;
			msg_q   <= MSG_NONE;
			motor_q <= 8'd0;
			servo_q <= 8'd0;
			led_q   <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			msg_q   <= msg_d;
			motor_q <= motor_d;
			servo_q <= servo_d;
			led_q   <= led_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tx_kind        <= kind_d;
			tx_echo        <= echo_d;
			actuator_send  <= send_d;
			motor_cmd      <= motor_d;
			servo_cmd      <= servo_d;
			stop_actuators <= stop_d;
			led_on         <= led_d;
			link_state     <= phase_d;
		end
	end

	// echo of a frame always comes with actuator commands
	a_echo_sends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tx_kind == TX_ECHO |-> actuator_send && link_state == PH_RUNNING)
		else $error("echo without actuator commands");

	// stopping actuators only happens while blocked, sending BLCKST
	a_stop_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stop_actuators |-> tx_kind == TX_BLCKST && link_state == PH_BLOCKED
			&& !actuator_send)
		else $error("stop outside blocked phase");

	// a refresh returns the link to running with the led toggled
	a_refresh_resumes: assert property (@(posedge clk) disable iff (!arst_n)
		advance && kind_d == TX_REFRSH |=> link_state == PH_RUNNING && led_on != $past(led_q))
		else $error("refresh did not resume the link");

	// a stalled input register always holds an item
	a_stall_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled with no reason");

	// state only moves when a result is captured
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(phase_q) && $stable(led_q) && $stable(msg_q))
		else $error("state changed without an item");

endmodule
`default_nettype wire

FILE: tb/sv/link_handshake_command_supervisor_tb.sv
// testbench for the link handshake command supervisor: streams poll items and checks every result item
`timescale 1ns / 100ps
module link_handshake_command_supervisor_tb;
	import lhcs_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	// two register stages between an accepted item and its result
	localparam int unsigned SETTLE_CYCLES = 6;

	// ascii framing characters of the link protocol
	localparam logic [7:0] CHAR_LT = 8'h3C;
	localparam logic [7:0] CHAR_GT = 8'h3E;

	// one result item as the supervisor presents it
	typedef struct packed {
		logic [2:0]  kind;
		logic [63:0] echo;
		logic        send;
		logic [7:0]  motor;
		logic [7:0]  servo;
		logic        halt;
		logic        led;
		logic [1:0]  state;
	} tick_result_t;

	// mirrors the supervisor state and keeps the expected result items in order
	class supervisor_board;
		logic [1:0]     phase;
		logic [1:0]     msg_kind;
		logic [7:0]     motor;
		logic [7:0]     servo;
		logic           led;
		logic [31:0]    timeout;
		tick_result_t   expected_ticks[$];
		int unsigned    fail_count;
		int unsigned    tick_count;

		function new();
			phase = PH_UNLINKED;
			msg_kind = MSG_NONE;
			motor = '0;
			servo = '0;
			led = 1'b0;
			timeout = TIMEOUT_RESET;
			fail_count = 0;
			tick_count = 0;
		endfunction

		function void set_timeout(logic [31:0] value);
			timeout = value;
		endfunction

		function int unsigned pending_count();
			return expected_ticks.size();
		endfunction

		// ascii digit pair to a value, wrapped to eight bits
		function logic [7:0] ascii_pair(logic [7:0] hi, logic [7:0] lo);
			logic [7:0] value;
			value = (hi - ASCII_ZERO) * 8'd10 + (lo - ASCII_ZERO);
			return value;
		endfunction

		// decode the frame, advance the phase and queue the expected result
		function void take_poll(logic [63:0] frame, logic fresh, logic [31:0] idle);
			tick_result_t r;
			r = '0;
			r.kind = TX_NONE;
			if (frame == ACCEPT_TEXT) begin
				msg_kind = MSG_ACCEPTED;
			end else if (frame[15:8] == CHAR_M && frame[39:32] == CHAR_S) begin
				msg_kind = MSG_COMMAND;
				motor = ascii_pair(frame[23:16], frame[31:24]);
				servo = ascii_pair(frame[47:40], frame[55:48]);
			end
			case (phase)
				PH_UNLINKED: begin
					r.kind = TX_CONREQ;
					if (msg_kind == MSG_ACCEPTED) begin
						phase = PH_RUNNING;
						led = ~led;
					end
				end
				PH_BLOCKED: begin
					if (fresh) begin
						r.kind = TX_REFRSH;
						led = ~led;
						r.send = 1'b1;
						phase = PH_RUNNING;
					end else begin
						r.halt = 1'b1;
						r.kind = TX_BLCKST;
					end
				end
				default: begin
					if (fresh) begin
						led = ~led;
						r.send = 1'b1;
						r.kind = TX_ECHO;
						r.echo = frame;
					end else if (idle >= timeout) begin
						led = 1'b1;
						phase = PH_BLOCKED;
					end
				end
			endcase
			r.motor = motor;
			r.servo = servo;
			r.led = led;
			r.state = phase;
			expected_ticks.push_back(r);
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			fail_count++;
		endtask

		task check_tick(tick_result_t got);
			tick_result_t exp;
			if (expected_ticks.size() == 0) begin
				report($sformatf("result item %0d arrived with nothing expected", tick_count));
			end else begin
				exp = expected_ticks.pop_front();
				if (got.kind !== exp.kind)
					report($sformatf("item %0d tx_kind %0d, expected %0d",
						tick_count, got.kind, exp.kind));
				if (got.echo !== exp.echo)
					report($sformatf("item %0d tx_echo %h, expected %h",
						tick_count, got.echo, exp.echo));
				if (got.send !== exp.send)
					report($sformatf("item %0d actuator_send %b, expected %b",
						tick_count, got.send, exp.send));
				if (got.motor !== exp.motor)
					report($sformatf("item %0d motor_cmd %0d, expected %0d",
						tick_count, got.motor, exp.motor));
				if (got.servo !== exp.servo)
					report($sformatf("item %0d servo_cmd %0d, expected %0d",
						tick_count, got.servo, exp.servo));
				if (got.halt !== exp.halt)
					report($sformatf("item %0d stop_actuators %b, expected %b",
						tick_count, got.halt, exp.halt));
				if (got.led !== exp.led)
					report($sformatf("item %0d led_on %b, expected %b",
						tick_count, got.led, exp.led));
				if (got.state !== exp.state)
					report($sformatf("item %0d link_state %0d, expected %0d",
						tick_count, got.state, exp.state));
			end
			tick_count++;
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] rx_frame;
	logic        frame_is_new;
	logic [31:0] idle_time;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  tx_kind;
	logic [63:0] tx_echo;
	logic        actuator_send;
	logic [7:0]  motor_cmd;
	logic [7:0]  servo_cmd;
	logic        stop_actuators;
	logic        led_on;
	logic [1:0]  link_state;

	supervisor_board board;
	logic [31:0]     cur_timeout;
	int unsigned     burst_left;
	int unsigned     cycle_count;

	link_handshake_command_supervisor dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_frame       (rx_frame),
		.frame_is_new   (frame_is_new),
		.idle_time      (idle_time),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.tx_kind        (tx_kind),
		.tx_echo        (tx_echo),
		.actuator_send  (actuator_send),
		.motor_cmd      (motor_cmd),
		.servo_cmd      (servo_cmd),
		.stop_actuators (stop_actuators),
		.led_on         (led_on),
		.link_state     (link_state)
	);

	// 8 ns clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("link_handshake_command_supervisor verification failed");
			$finish;
		end
	end

	// receiver: the stall pattern switches between modes at random
	// mode 0 never stalls, mode 1 stalls at random, mode 2 stalls on a fixed beat
	initial begin
		int unsigned stall_mode;
		int unsigned mode_left;
		stall_mode = 0;
		mode_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 80);
			end
			mode_left--;
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 2) == 0);
				default: out_stall <= ((mode_left % 8) < 5);
			endcase
		end
	end

	// result items are taken at the rising edge, before the block updates
	always @(posedge clk) begin
		tick_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.kind = tx_kind;
			got.echo = tx_echo;
			got.send = actuator_send;
			got.motor = motor_cmd;
			got.servo = servo_cmd;
			got.halt = stop_actuators;
			got.led = led_on;
			got.state = link_state;
			board.check_tick(got);
		end
	end

	// "<Mab" "Scd>" with byte 0 in the low bits
	function automatic logic [63:0] command_frame(logic [7:0] m_hi, logic [7:0] m_lo,
			logic [7:0] s_hi, logic [7:0] s_lo);
		return {CHAR_GT, s_lo, s_hi, CHAR_S, m_lo, m_hi, CHAR_M, CHAR_LT};
	endfunction

	// an ascii digit most of the time, any byte now and then
	function automatic logic [7:0] rand_digit();
		if ($urandom_range(0, 6) == 0)
			return 8'($urandom);
		return ASCII_ZERO + 8'($urandom_range(0, 9));
	endfunction

	// idle times cluster around the current timeout so both sides of it are hit
	function automatic logic [31:0] rand_idle();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return cur_timeout - 32'd1;
			2: return cur_timeout;
			3: return cur_timeout + 32'd1;
			4: return 32'hFFFF_FFFF;
			5: return (cur_timeout == 0) ? 32'd0 : 32'($urandom_range(0, cur_timeout - 1));
			default: return $urandom;
		endcase
	endfunction

	// one poll item, with the sender pausing between bursts of random length
	task automatic send_poll(logic [63:0] frame, logic fresh, logic [31:0] idle);
		int unsigned gap;
		if (burst_left == 0) begin
			// about a quarter of the bursts follow on with no gap
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		rx_frame <= frame;
		frame_is_new <= fresh;
		idle_time <= idle;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		board.take_poll(frame, fresh, idle);
		@(negedge clk);
	endtask

	// random poll: command and accept frames for under half, the rest near misses and noise
	task automatic send_random_poll();
		logic [63:0] frame;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 35)
			frame = command_frame(rand_digit(), rand_digit(), rand_digit(), rand_digit());
		else if (pick < 45)
			frame = ACCEPT_TEXT;
		else if (pick < 55)
			frame = ACCEPT_TEXT ^ (64'd1 << $urandom_range(0, 63));
		else if (pick < 65)
			frame = command_frame(rand_digit(), rand_digit(), rand_digit(), rand_digit())
				^ (64'd1 << $urandom_range(0, 63));
		else
			frame = {$urandom, $urandom};
		send_poll(frame, 1'($urandom_range(0, 1)), rand_idle());
	endtask

	// wait until every expected result is back and the pipeline is empty
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (board.pending_count() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_timeout(logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		board.set_timeout(value);
		cur_timeout = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [31:0] phase_timeouts[5];
		board = new();
		cycle_count = 0;
		burst_left = 0;
		cur_timeout = TIMEOUT_RESET;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		rx_frame = '0;
		frame_is_new = 1'b0;
		idle_time = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part, reset timeout of 1000
		// unlinked: only CONREQ goes out whatever arrives, commands still update values
		send_poll(64'd0, 1'b0, 32'd0);
		send_poll(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
		send_poll(command_frame("1", "2", "3", "4"), 1'b1, 32'd0);
		// accept text with the last byte wrong is not an accept
		send_poll(ACCEPT_TEXT ^ 64'h0100_0000_0000_0000, 1'b1, 32'd5);
		// non-digit characters still go through the digit formula
		send_poll(command_frame("z", "z", "/", "/"), 1'b1, 32'd0);
		// accept on a stale frame still links
		send_poll(ACCEPT_TEXT, 1'b0, 32'd0);
		// running: new frames are echoed and drive the actuators
		send_poll(command_frame("9", "9", "9", "9"), 1'b1, 32'd0);
		send_poll(ACCEPT_TEXT, 1'b1, 32'd0);
		// idle just under the timeout does nothing, at the timeout blocks
		send_poll({$urandom, $urandom}, 1'b0, 32'd999);
		send_poll({$urandom, $urandom}, 1'b0, 32'd1000);
		// blocked: stale frames stop the actuators, a new one refreshes
		send_poll(64'd0, 1'b0, 32'd0);
		send_poll(command_frame("0", "0", "0", "0"), 1'b1, 32'd0);
		send_poll(64'd0, 1'b0, 32'hFFFF_FFFF);
		send_poll({$urandom, $urandom}, 1'b1, 32'd0);
		// M without S is not a command
		send_poll({CHAR_GT, "77", "X", "55", CHAR_M, CHAR_LT}, 1'b1, 32'd0);
		send_poll(command_frame(8'hFF, 8'h00, 8'h00, 8'hFF), 1'b1, 32'd0);
		repeat (100) send_random_poll();

		// further phases at other timeouts, extremes included
		phase_timeouts[0] = 32'd0;
		phase_timeouts[1] = 32'hFFFF_FFFF;
		phase_timeouts[2] = $urandom;
		phase_timeouts[3] = $urandom_range(1, 40);
		phase_timeouts[4] = 32'd1;
		foreach (phase_timeouts[p]) begin
			drain();
			write_timeout(phase_timeouts[p]);
			repeat (110) send_random_poll();
		end

		drain();
		if (board.fail_count == 0)
			$display("link_handshake_command_supervisor verification clean");
		else
			$display("link_handshake_command_supervisor verification failed");
		$finish;
	end

endmodule

FILE: sim.f
rtl/lhcs_pkg.sv
rtl/link_handshake_command_supervisor.sv
tb/sv/link_handshake_command_supervisor_tb.sv
